@@ rtl/core/rmf_pkg.sv @@
// Shared types, constants and controller/datapath interface for the running median filter.
`timescale 1ns / 1ps
package rmf_pkg;

  localparam int WINDOW_MAX = 32;
  localparam int SAMPLE_W   = 32;
  localparam int IDX_W      = $clog2(WINDOW_MAX);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CFG_W      = 6;
  localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(5);

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_DRAIN  = 1'b1;

  typedef struct packed {
    logic                       op;
    logic signed [SAMPLE_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] median;
    logic                       last;
    logic                       draining;
  } out_word_t;

  // read address of the sorted store: slot zero, relative to the hole pointer, or the middle
  typedef enum logic [2:0] {
    RA_ZERO,
    RA_HOLE_M1,
    RA_HOLE_M2,
    RA_HOLE_P1,
    RA_HOLE_P2,
    RA_MED_HI,
    RA_MED_LO
  } ra_sel_t;

  typedef enum logic {
    WD_SAMP,
    WD_RDATA
  } wd_sel_t;

  typedef enum logic [2:0] {
    HOLE_KEEP,
    HOLE_FCNT,
    HOLE_ZERO,
    HOLE_INC,
    HOLE_DEC
  } hole_op_t;

  typedef enum logic [1:0] {
    CNT_KEEP,
    CNT_INC,
    CNT_DEC,
    CNT_CLEAR
  } cnt_op_t;

  typedef struct packed {
    logic     accept;
    logic     ring_fill_wr;
    logic     ring_rep_wr;
    logic     old_ld;
    logic     optr_adv;
    ra_sel_t  s_rsel;
    logic     s_we;
    wd_sel_t  s_wsel;
    hole_op_t hole_op;
    cnt_op_t  cnt_op;
    logic     hi_ld;
    logic     sum_ld;
    logic     emit;
    logic     emit_last;
    logic     emit_drain;
  } cmd_t;

  typedef struct packed {
    logic fill;           // fewer samples held than the window
    logic post_over;      // count after one more insert exceeds half the window
    logic drain_more;     // count exceeds half the window plus one
    logic hole_zero;
    logic hole_one;
    logic hole_last;      // hole is the top occupied slot
    logic hole_next_last; // hole + 1 is the top occupied slot
    logic rd_gt;          // stored word above the new sample
    logic rd_lt;          // stored word below the new sample
    logic rd_eq_old;      // stored word matches the outgoing sample
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/rmf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/rmf_ctrl.sv @@
// Sequencer for the running median filter: insert, replace, drain and median steps.
`timescale 1ns / 1ps
module rmf_ctrl
  import rmf_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RING_WR,
    ST_INS_START,
    ST_DN,
    ST_UP,
    ST_PUT,
    ST_POST,
    ST_OLD_RD,
    ST_OLD_LD,
    ST_FIND,
    ST_SHU_START,
    ST_SHU,
    ST_DR_CHK,
    ST_DR_DEC,
    ST_MED,
    ST_MED1,
    ST_MED2,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   drain_r, drain_nxt;
  logic   full_r, full_nxt;
  logic   up_ok_r, up_ok_nxt;

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    drain_nxt = drain_r;
    full_nxt  = full_r;
    up_ok_nxt = up_ok_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_op == OP_DRAIN) begin
            drain_nxt = 1'b1;
            full_nxt  = 1'b0;
            state_nxt = ST_DR_CHK;
          end else if (sts.fill) begin
            drain_nxt = 1'b0;
            full_nxt  = 1'b0;
            state_nxt = ST_RING_WR;
          end else begin
            drain_nxt = 1'b0;
            full_nxt  = 1'b1;
            state_nxt = ST_OLD_RD;
          end
        end
      end
      ST_RING_WR: begin
        cmd.ring_fill_wr = 1'b1;
        cmd.hole_op      = HOLE_FCNT;
        up_ok_nxt        = 1'b0;
        state_nxt        = ST_INS_START;
      end
      ST_INS_START: begin
        if (sts.hole_zero) begin
          if (up_ok_r && !sts.hole_last) begin
            cmd.s_rsel = RA_HOLE_P1;
            up_ok_nxt  = 1'b0;
            state_nxt  = ST_UP;
          end else begin
            state_nxt = ST_PUT;
          end
        end else begin
          cmd.s_rsel = RA_HOLE_M1;
          state_nxt  = ST_DN;
        end
      end
      // walk the hole downward while the word below is larger
      ST_DN: begin
        if (sts.rd_gt) begin
          cmd.s_we    = 1'b1;
          cmd.s_wsel  = WD_RDATA;
          cmd.hole_op = HOLE_DEC;
          up_ok_nxt   = 1'b0;
          if (sts.hole_one) begin
            state_nxt = ST_PUT;
          end else begin
            cmd.s_rsel = RA_HOLE_M2;
          end
        end else if (up_ok_r && !sts.hole_last) begin
          cmd.s_rsel = RA_HOLE_P1;
          up_ok_nxt  = 1'b0;
          state_nxt  = ST_UP;
        end else begin
          cmd.s_we   = 1'b1;
          cmd.s_wsel = WD_SAMP;
          state_nxt  = ST_POST;
        end
      end
      // walk the hole upward while the word above is smaller
      ST_UP: begin
        if (sts.rd_lt) begin
          cmd.s_we    = 1'b1;
          cmd.s_wsel  = WD_RDATA;
          cmd.hole_op = HOLE_INC;
          if (sts.hole_next_last) begin
            state_nxt = ST_PUT;
          end else begin
            cmd.s_rsel = RA_HOLE_P2;
          end
        end else begin
          cmd.s_we   = 1'b1;
          cmd.s_wsel = WD_SAMP;
          state_nxt  = ST_POST;
        end
      end
      ST_PUT: begin
        cmd.s_we   = 1'b1;
        cmd.s_wsel = WD_SAMP;
        state_nxt  = ST_POST;
      end
      ST_POST: begin
        if (full_r) begin
          state_nxt = ST_MED;
        end else begin
          cmd.cnt_op = CNT_INC;
          state_nxt  = sts.post_over ? ST_MED : ST_IDLE;
        end
      end
      ST_OLD_RD: begin
        state_nxt = ST_OLD_LD;
      end
      ST_OLD_LD: begin
        cmd.old_ld      = 1'b1;
        cmd.optr_adv    = 1'b1;
        cmd.ring_rep_wr = !drain_r;
        cmd.s_rsel      = RA_ZERO;
        cmd.hole_op     = HOLE_ZERO;
        state_nxt       = ST_FIND;
      end
      ST_FIND: begin
        if (sts.rd_eq_old || sts.hole_last) begin
          up_ok_nxt = 1'b1;
          state_nxt = drain_r ? ST_SHU_START : ST_INS_START;
        end else begin
          cmd.hole_op = HOLE_INC;
          cmd.s_rsel  = RA_HOLE_P1;
        end
      end
      ST_SHU_START: begin
        if (sts.hole_last) begin
          state_nxt = ST_DR_DEC;
        end else begin
          cmd.s_rsel = RA_HOLE_P1;
          state_nxt  = ST_SHU;
        end
      end
      // close the gap left by the removed word
      ST_SHU: begin
        cmd.s_we    = 1'b1;
        cmd.s_wsel  = WD_RDATA;
        cmd.hole_op = HOLE_INC;
        if (sts.hole_next_last) begin
          state_nxt = ST_DR_DEC;
        end else begin
          cmd.s_rsel = RA_HOLE_P2;
        end
      end
      ST_DR_CHK: begin
        if (sts.drain_more) begin
          state_nxt = ST_OLD_LD;
        end else begin
          cmd.cnt_op = CNT_CLEAR;
          drain_nxt  = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      ST_DR_DEC: begin
        cmd.cnt_op = CNT_DEC;
        state_nxt  = ST_MED;
      end
      ST_MED: begin
        cmd.s_rsel = RA_MED_HI;
        state_nxt  = ST_MED1;
      end
      ST_MED1: begin
        cmd.hi_ld  = 1'b1;
        cmd.s_rsel = RA_MED_LO;
        state_nxt  = ST_MED2;
      end
      ST_MED2: begin
        cmd.sum_ld = 1'b1;
        state_nxt  = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_last  = drain_r ? !sts.drain_more : 1'b1;
          cmd.emit_drain = drain_r;
          state_nxt      = drain_r ? ST_DR_CHK : ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      drain_r <= 1'b0;
      full_r  <= 1'b0;
      up_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      drain_r <= drain_nxt;
      full_r  <= full_nxt;
      up_ok_r <= up_ok_nxt;
    end
  end

endmodule

@@ rtl/core/rmf_dp.sv @@
// Datapath of the running median filter: sorted store, arrival ring, counters, median math.
`timescale 1ns / 1ps
module rmf_dp
  import rmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  in_word_t         in_word,
  input  logic             cfg_valid,
  input  logic [CFG_W-1:0] cfg_data,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word
);

  logic [CNT_W-1:0]           weff_r;
  logic [CNT_W-1:0]           fcnt_r, fcnt_nxt;
  logic [IDX_W-1:0]           optr_r, optr_nxt;
  logic [IDX_W-1:0]           hole_r, hole_nxt;
  logic signed [SAMPLE_W-1:0] samp_r;
  logic signed [SAMPLE_W-1:0] old_r;
  logic signed [SAMPLE_W-1:0] hi_r;
  logic signed [SAMPLE_W:0]   sum_r;
  logic                       out_valid_r;
  out_word_t                  out_word_r;

  logic [CNT_W-1:0]    half;
  logic [CNT_W:0]      fill_sum;
  logic [CNT_W:0]      fill_wrap;
  logic [IDX_W-1:0]    fill_addr;
  logic [IDX_W-1:0]    optr_inc;
  logic [IDX_W-1:0]    med_hi;
  logic [IDX_W-1:0]    s_raddr;
  logic [SAMPLE_W-1:0] s_wdata;
  logic [SAMPLE_W-1:0] s_rdata;
  logic                r_we;
  logic [IDX_W-1:0]    r_waddr;
  logic [SAMPLE_W-1:0] r_rdata;
  logic [SAMPLE_W:0]   sum_adj;
  logic [CNT_W-1:0]    weff_cfg;

  assign half      = weff_r >> 1;
  assign fill_sum  = {2'b00, optr_r} + {1'b0, fcnt_r};
  assign fill_wrap = (fill_sum >= {1'b0, weff_r}) ? (fill_sum - {1'b0, weff_r}) : fill_sum;
  assign fill_addr = fill_wrap[IDX_W-1:0];
  assign optr_inc  = ({1'b0, optr_r} + CNT_W'(1) == weff_r) ? '0 : optr_r + IDX_W'(1);
  assign med_hi    = fcnt_r[CNT_W-1:1];

  // zero selects one, anything past the maximum saturates
  always_comb begin
    if (cfg_data == '0) begin
      weff_cfg = CNT_W'(1);
    end else if ({1'b0, cfg_data} > (CFG_W + 1)'(WINDOW_MAX)) begin
      weff_cfg = CNT_W'(WINDOW_MAX);
    end else begin
      weff_cfg = CNT_W'(cfg_data);
    end
  end

  always_comb begin
    case (cmd.s_rsel)
      RA_ZERO:    s_raddr = '0;
      RA_HOLE_M1: s_raddr = hole_r - IDX_W'(1);
      RA_HOLE_M2: s_raddr = hole_r - IDX_W'(2);
      RA_HOLE_P1: s_raddr = hole_r + IDX_W'(1);
      RA_HOLE_P2: s_raddr = hole_r + IDX_W'(2);
      RA_MED_HI:  s_raddr = med_hi;
      RA_MED_LO:  s_raddr = fcnt_r[0] ? med_hi : med_hi - IDX_W'(1);
      default:    s_raddr = '0;
    endcase
  end

  assign s_wdata = (cmd.s_wsel == WD_RDATA) ? s_rdata : samp_r;

  rmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_sorted (
    .clk   (clk),
    .we    (cmd.s_we),
    .waddr (hole_r),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  assign r_we    = cmd.ring_fill_wr | cmd.ring_rep_wr;
  assign r_waddr = cmd.ring_fill_wr ? fill_addr : optr_r;

  rmf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_MAX)
  ) u_ring (
    .clk   (clk),
    .we    (r_we),
    .waddr (r_waddr),
    .wdata (samp_r),
    .raddr (optr_r),
    .rdata (r_rdata)
  );

  always_comb begin
    case (cmd.hole_op)
      HOLE_KEEP: hole_nxt = hole_r;
      HOLE_FCNT: hole_nxt = fcnt_r[IDX_W-1:0];
      HOLE_ZERO: hole_nxt = '0;
      HOLE_INC:  hole_nxt = hole_r + IDX_W'(1);
      HOLE_DEC:  hole_nxt = hole_r - IDX_W'(1);
      default:   hole_nxt = hole_r;
    endcase
  end

  always_comb begin
    fcnt_nxt = fcnt_r;
    optr_nxt = cmd.optr_adv ? optr_inc : optr_r;
    case (cmd.cnt_op)
      CNT_KEEP: fcnt_nxt = fcnt_r;
      CNT_INC:  fcnt_nxt = fcnt_r + CNT_W'(1);
      CNT_DEC:  fcnt_nxt = fcnt_r - CNT_W'(1);
      CNT_CLEAR: begin
        fcnt_nxt = '0;
        optr_nxt = '0;
      end
      default:  fcnt_nxt = fcnt_r;
    endcase
    if (cfg_valid) begin
      fcnt_nxt = '0;
      optr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      weff_r      <= WINDOW_RESET;
      fcnt_r      <= '0;
      optr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        weff_r <= weff_cfg;
      end
      fcnt_r <= fcnt_nxt;
      optr_r <= optr_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // truncate toward zero: bias a negative sum by one before halving
  assign sum_adj = sum_r + {{SAMPLE_W{1'b0}}, sum_r[SAMPLE_W]};

  always_ff @(posedge clk) begin
    hole_r <= hole_nxt;
    if (cmd.accept) begin
      samp_r <= in_word.sample;
    end
    if (cmd.old_ld) begin
      old_r <= r_rdata;
    end
    if (cmd.hi_ld) begin
      hi_r <= s_rdata;
    end
    if (cmd.sum_ld) begin
      sum_r <= {hi_r[SAMPLE_W-1], hi_r} + {s_rdata[SAMPLE_W-1], s_rdata};
    end
    if (cmd.emit) begin
      out_word_r.median   <= sum_adj[SAMPLE_W:1];
      out_word_r.last     <= cmd.emit_last;
      out_word_r.draining <= cmd.emit_drain;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  always_comb begin
    sts.fill           = (fcnt_r < weff_r);
    sts.post_over      = (fcnt_r + CNT_W'(1)) > half;
    sts.drain_more     = fcnt_r > (half + CNT_W'(1));
    sts.hole_zero      = (hole_r == '0);
    sts.hole_one       = (hole_r == IDX_W'(1));
    sts.hole_last      = ({1'b0, hole_r} + CNT_W'(1)) == fcnt_r;
    sts.hole_next_last = ({1'b0, hole_r} + CNT_W'(2)) == fcnt_r;
    sts.rd_gt          = $signed(s_rdata) > samp_r;
    sts.rd_lt          = $signed(s_rdata) < samp_r;
    sts.rd_eq_old      = $signed(s_rdata) == old_r;
    sts.out_free       = !out_valid_r || !out_stall;
  end

  a_fcnt_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    fcnt_r <= weff_r)
    else $error("fill count above window");

  a_weff_range: assert property (@(posedge clk) disable iff (!rst_n)
    (weff_r != '0) && (weff_r <= CNT_W'(WINDOW_MAX)))
    else $error("effective window out of range");

  a_optr_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, optr_r} < weff_r)
    else $error("oldest pointer outside window");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("result word loaded over an untaken word");

endmodule

@@ rtl/core/running_median_filter.sv @@
// Top level of the running median filter: controller, datapath and port wiring.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall   | in_word_t  (op, sample)
//  out_    | output    | out_valid/out_stall | out_word_t (median, last, draining)
//  cfg_    | input     | cfg_valid/cfg_ready | window size, 6 bits
//
// One item at a time. A sample in the fill phase takes a ring write, an insertion
// walk that moves one word per step and, once over half the window, two median reads.
// A sample into a full window first finds the outgoing word in the sorted store, one
// entry at a time, then walks the new word to its place from there, one entry at a
// time; the one read port of the sorted store sets the pace of both.
// A drain step costs a similar find plus a closing shift per result word.
// Reset is synchronous, active low; there is no clearing pass.
// A stalled result holds in the output register; the next item is still accepted
// and waits only when its own result is ready.
`timescale 1ns / 1ps
module running_median_filter
  import rmf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_word_t         in_word,
  output logic             out_valid,
  input  logic             out_stall,
  output out_word_t        out_word,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rmf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_word.op),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
